// ----- rtl/core/key_value_argument_extractor_defines.svh -----
`ifndef KEY_VALUE_ARGUMENT_EXTRACTOR_DEFINES_SVH
`define KEY_VALUE_ARGUMENT_EXTRACTOR_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define KVAE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked during reset as well.
`define KVAE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/kvae_pkg.sv -----
`default_nettype none

package kvae_pkg;

  localparam int unsigned MAX_KEY_BYTES_DEF = 8;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_EQ  = 8'h3d;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_NL  = 8'h0a;

  typedef enum logic [1:0] {
    KIND_VALUE   = 2'd0,
    KIND_FOUND   = 2'd1,
    KIND_MISSING = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_KEY_CHARS   = 2'd0,
    REG_KEY_LENGTH  = 2'd1,
    REG_VALUE_LIMIT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic push;
    logic clear;
  } win_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/kvae_if.sv -----
`default_nettype none

interface kvae_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

interface kvae_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value_char;
  logic       last;
  modport source (output valid, output kind, output value_char, output last, input ready);
  modport sink (input valid, input kind, input value_char, input last, output ready);
endinterface

interface kvae_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/kvae_cell.sv -----
`default_nettype none

module kvae_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire kvae_pkg::win_ctrl_t ctrl_i,
  input  wire logic [7:0]          left_byte_i,
  input  wire logic                left_valid_i,
  input  wire logic [7:0]          key_byte_i,
  input  wire logic                used_i,
  output logic [7:0]               byte_o,
  output logic                     valid_o,
  output logic                     hit_o
);
  import kvae_pkg::*;

  logic [7:0] byte_q;
  logic       valid_q;
  logic       valid_d;

  // compare against the byte this cell holds after the shift
  assign hit_o = !used_i || (left_valid_i && (left_byte_i == key_byte_i));

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.push) begin
      valid_d = left_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      byte_q <= left_byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/kvae_ctrl.sv -----
`default_nettype none
`include "key_value_argument_extractor_defines.svh"

module kvae_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [7:0]          in_char_i,
  output logic                     in_ready_o,
  input  wire logic                match_i,
  input  wire logic [7:0]          value_limit_i,
  output kvae_pkg::win_ctrl_t      win_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               kind_o,
  output logic [7:0]               value_char_o,
  output logic                     last_o
);
  import kvae_pkg::*;

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_MATCHED = 2'd1,
    PH_COPY    = 2'd2,
    PH_DONE    = 2'd3
  } phase_e;

  phase_e     phase_q;
  logic [7:0] copied_q;
  logic       out_valid_q;
  kind_e      kind_q;
  logic [7:0] value_char_q;
  logic       last_q;

  logic       accept;
  logic       is_nul;
  logic       is_eq;
  logic       is_ws;
  logic [7:0] cap;
  logic       limit_hit;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_nul     = (in_char_i == CHAR_NUL);
  assign is_eq      = (in_char_i == CHAR_EQ);
  assign is_ws      = (in_char_i == CHAR_SP) || (in_char_i == CHAR_TAB) ||
                      (in_char_i == CHAR_NL);
  assign cap        = (value_limit_i == 8'd0) ? 8'd0 : value_limit_i - 8'd1;
  assign limit_hit  = (copied_q >= cap);

  always_comb begin
    win_o.push  = accept && !is_nul &&
                  ((phase_q == PH_SEARCH) || ((phase_q == PH_MATCHED) && !is_eq));
    win_o.clear = (accept && is_nul) || (win_o.push && match_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SEARCH;
      copied_q     <= 8'd0;
      out_valid_q  <= 1'b0;
      kind_q       <= KIND_VALUE;
      value_char_q <= 8'd0;
      last_q       <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        unique case (phase_q)
          PH_SEARCH, PH_MATCHED: begin
            if (is_nul) begin
              phase_q      <= PH_SEARCH;
              copied_q     <= 8'd0;
              out_valid_q  <= 1'b1;
              kind_q       <= KIND_MISSING;
              value_char_q <= 8'd0;
              last_q       <= 1'b1;
            end else if ((phase_q == PH_MATCHED) && is_eq) begin
              phase_q  <= PH_COPY;
              copied_q <= 8'd0;
            end else begin
              phase_q <= match_i ? PH_MATCHED : PH_SEARCH;
            end
          end
          PH_COPY: begin
            out_valid_q <= 1'b1;
            if (limit_hit || is_nul || is_ws) begin
              phase_q      <= is_nul ? PH_SEARCH : PH_DONE;
              copied_q     <= is_nul ? 8'd0 : copied_q;
              kind_q       <= KIND_FOUND;
              value_char_q <= 8'd0;
              last_q       <= 1'b1;
            end else begin
              copied_q     <= copied_q + 8'd1;
              kind_q       <= KIND_VALUE;
              value_char_q <= in_char_i;
              last_q       <= 1'b0;
            end
          end
          PH_DONE: begin
            if (is_nul) begin
              phase_q  <= PH_SEARCH;
              copied_q <= 8'd0;
            end
          end
          default: begin
            phase_q <= PH_SEARCH;
          end
        endcase
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign value_char_o = value_char_q;
  assign last_o       = last_q;

  `KVAE_ASSERT(a_last_marks_end, clk_i, rst_ni, out_valid_q |-> (last_q == (kind_q != KIND_VALUE)), "last flag does not match result kind")
  `KVAE_ASSERT(a_nul_restarts, clk_i, rst_ni, (accept && is_nul) |=> (phase_q == PH_SEARCH), "end of string did not restart the search")
  `KVAE_ASSERT(a_done_silent, clk_i, rst_ni, ((phase_q == PH_DONE) && accept) |=> !out_valid_q, "item after a found result produced output")

endmodule

`default_nettype wire

// ----- rtl/core/key_value_argument_extractor.sv -----
// Scans an argument string one byte per item, zero byte ends the string, for the configured
// key followed by '=' and streams out the value bytes, then a found or not-found result with
// last set. Each byte passes through a row of MAX_KEY_BYTES window cells that compare it with
// the key in the same cycle, so a byte is accepted every clock while the output register is
// empty or being drained, and its result, if any, appears in the cycle after acceptance.
// The configuration port is always ready; write registers only between strings.
`default_nettype none

module key_value_argument_extractor #(
  parameter int unsigned MAX_KEY_BYTES = kvae_pkg::MAX_KEY_BYTES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kvae_cfg_if.sink  cfg_i,
  kvae_in_if.sink   in_i,
  kvae_out_if.source out_o
);
  import kvae_pkg::*;

  logic [63:0] key_chars_q;
  logic [3:0]  key_length_q;
  logic [7:0]  value_limit_q;

  logic [3:0]  len_used;
  logic [7:0]  key_bytes [8];
  logic [7:0]  win_byte  [MAX_KEY_BYTES];
  logic        win_valid [MAX_KEY_BYTES];
  logic [MAX_KEY_BYTES-1:0] hit;
  logic        match;
  win_ctrl_t   win_ctrl;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_chars_q   <= 64'd0;
      key_length_q  <= 4'd1;
      value_limit_q <= 8'd64;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_KEY_CHARS:   key_chars_q   <= cfg_i.data;
        REG_KEY_LENGTH:  key_length_q  <= cfg_i.data[3:0];
        REG_VALUE_LIMIT: value_limit_q <= cfg_i.data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    priority if (key_length_q == 4'd0) begin
      len_used = 4'd1;
    end else if (key_length_q > 4'(MAX_KEY_BYTES)) begin
      len_used = 4'(MAX_KEY_BYTES);
    end else begin
      len_used = key_length_q;
    end
  end

  for (genvar k = 0; k < 8; k++) begin : g_key
    assign key_bytes[k] = key_chars_q[8*k +: 8];
  end

  for (genvar j = 0; j < MAX_KEY_BYTES; j++) begin : g_cell
    logic [3:0] key_idx;
    logic [7:0] left_byte;
    logic       left_valid;

    assign key_idx = len_used - 4'd1 - 4'(j);

    if (j == 0) begin : g_head
      assign left_byte  = in_i.in_char;
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_byte  = win_byte[j-1];
      assign left_valid = win_valid[j-1];
    end

    kvae_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (win_ctrl),
      .left_byte_i  (left_byte),
      .left_valid_i (left_valid),
      .key_byte_i   (key_bytes[key_idx[2:0]]),
      .used_i       (4'(j) < len_used),
      .byte_o       (win_byte[j]),
      .valid_o      (win_valid[j]),
      .hit_o        (hit[j])
    );
  end

  assign match = &hit;

  kvae_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_char_i     (in_i.in_char),
    .in_ready_o    (in_i.ready),
    .match_i       (match),
    .value_limit_i (value_limit_q),
    .win_o         (win_ctrl),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .kind_o        (out_o.kind),
    .value_char_o  (out_o.value_char),
    .last_o        (out_o.last)
  );

endmodule

`default_nettype wire
